// File: rtl/plp_pkg.sv
`timescale 1ns / 1ps
package plp_pkg;

   localparam int REQ_DATA_W = 320;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 192;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_LIGHT_POS_X = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIGHT_POS_Y = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIGHT_POS_Z = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIGHT_RED   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIGHT_GREEN = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIGHT_BLUE  = 3'd5;

   localparam int QUEUE_DEPTH = 2;

   typedef logic [2:0][31:0] position_type;
   typedef logic [2:0][15:0] intensity_type;

   // one classified hit: offset from the hit to the light already formed
   typedef struct packed {
      logic [2:0][32:0] delta;
      logic [59:0]      normal;
      logic [59:0]      view;
      logic [47:0]      kd;
      logic [47:0]      ks;
      logic [7:0]       expo;
      logic             shadowed;
      logic             clear_first;
   } item_type;

   typedef enum logic [4:0] {
      BK_IDLE,
      BK_NORM,
      BK_SQ,
      BK_SQRT,
      BK_DIVLD,
      BK_DIV,
      BK_NL,
      BK_NLR,
      BK_RFM,
      BK_RFR,
      BK_RV,
      BK_RVR,
      BK_DFA,
      BK_DFM,
      BK_DFACC,
      BK_SPCHK,
      BK_PWM,
      BK_PWR,
      BK_SPA,
      BK_SPH,
      BK_SPL,
      BK_SPT,
      BK_SPACC,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } back_stat_type;

endpackage

// File: rtl/point_light_phong_shade.sv
`timescale 1ns / 1ps
// Channel   Ports                                  Transfer
// request   req_tvalid/tready, tdata, tuser        one hit point
// response  rsp_tvalid/tready, tdata               six accumulator values per hit
// config    csr_we, csr_index, csr_wdata           one register write per cycle
//
// A front register classifies each hit and forms light minus hit; a two-entry queue
// feeds the back sequencer. The time a lit hit takes is set by the bit-serial
// square root and the three 19-step divisions, plus a multiply state and a
// rounding state for each exponent step of the specular power loop. A shadowed
// hit goes from the idle state straight to the done state in the back. Reset is
// synchronous and clears the accumulators; the response register lets the back
// start the next hit while a result waits.
module point_light_phong_shade #(
   parameter int ACC_WIDTH     = 32,
   parameter int MAX_SHININESS = 255
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // hit_x, hit_y, hit_z, surface_normal, view_dir, diffuse_coeff, specular_coeff,
   // shininess
   input  logic [plp_pkg::REQ_DATA_W-1:0]      req_tdata,
   // shadowed, clear_first
   input  logic [plp_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // diffuse_red, diffuse_green, diffuse_blue, specular_red, specular_green,
   // specular_blue
   output logic [plp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [plp_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [plp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import plp_pkg::*;

   position_type  light_pos_ff, light_pos_in;
   intensity_type light_int_ff, light_int_in;

   logic          f_valid, f_ready;
   item_type      f_item;
   logic          q_valid;
   item_type      q_item;
   back_stat_type back_stat;

   always_comb begin
      light_pos_in = light_pos_ff;
      light_int_in = light_int_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LIGHT_POS_X: light_pos_in[0] = csr_wdata;
            CSR_LIGHT_POS_Y: light_pos_in[1] = csr_wdata;
            CSR_LIGHT_POS_Z: light_pos_in[2] = csr_wdata;
            CSR_LIGHT_RED:   light_int_in[0] = csr_wdata[15:0];
            CSR_LIGHT_GREEN: light_int_in[1] = csr_wdata[15:0];
            CSR_LIGHT_BLUE:  light_int_in[2] = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_pos_ff <= '0;
         light_int_ff <= '0;
      end else begin
         light_pos_ff <= light_pos_in;
         light_int_ff <= light_int_in;
      end
   end

   plp_front #(
      .MAX_SHININESS (MAX_SHININESS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .light_pos  (light_pos_ff),
      .out_valid  (f_valid),
      .out_ready  (f_ready),
      .out_item   (f_item)
   );

   plp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop        (back_stat.pop),
      .pop_item   (q_item)
   );

   plp_back #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .light_int  (light_int_ff),
      .stat       (back_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response valid straight after reset");

   a_pop_starts_work: assert property (@(posedge clock) disable iff (reset)
      back_stat.pop |=> back_stat.busy)
      else $error("back idle after taking an item");

   a_no_double_pop: assert property (@(posedge clock) disable iff (reset)
      back_stat.pop |=> !back_stat.pop)
      else $error("back took two items in a row");

endmodule

// File: rtl/plp_front.sv
`timescale 1ns / 1ps
module plp_front #(
   parameter int MAX_SHININESS = 255
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [plp_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [plp_pkg::REQ_USER_W-1:0]      req_tuser,
   input  plp_pkg::position_type               light_pos,
   output logic                                out_valid,
   input  logic                                out_ready,
   output plp_pkg::item_type                   out_item
);
   import plp_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   item_type cls;
   logic     take;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cls.delta[i] = {light_pos[i][31], light_pos[i]}
                      - {req_tdata[32*i+31], req_tdata[32*i +: 32]};
      end
      cls.normal      = req_tdata[155:96];
      cls.view        = req_tdata[215:156];
      cls.kd          = req_tdata[263:216];
      cls.ks          = req_tdata[311:264];
      // limit the exponent
      if ({2'b00, req_tdata[319:312]} > 10'(MAX_SHININESS)) begin
         cls.expo = 8'(MAX_SHININESS);
      end else begin
         cls.expo = req_tdata[319:312];
      end
      cls.shadowed    = req_tuser[0];
      cls.clear_first = req_tuser[1];
   end

   assign req_tready = !valid_ff || out_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      item_in  = take ? cls : item_ff;
      valid_in = take ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: rtl/plp_queue.sv
`timescale 1ns / 1ps
module plp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  plp_pkg::item_type  push_item,
   output logic               pop_valid,
   input  logic               pop,
   output plp_pkg::item_type  pop_item
);
   import plp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff < CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/plp_back.sv
`timescale 1ns / 1ps
module plp_back #(
   parameter int ACC_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  plp_pkg::item_type                q_item,
   input  plp_pkg::intensity_type           light_int,
   output plp_pkg::back_stat_type           stat,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [plp_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import plp_pkg::*;

   localparam int TERM_W = 41;
   localparam int SUM_W  = ((ACC_WIDTH > TERM_W) ? ACC_WIDTH : TERM_W) + 1;

   back_state_type state_ff, state_in;
   item_type       item_ff, item_in;
   logic [1:0]     idx_ff, idx_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic [7:0]     pcnt_ff, pcnt_in;
   logic [2:0][32:0] mag_ff, mag_in;
   logic [32:0]    max_ff, max_in;
   logic [61:0]    sq_ff, sq_in;
   logic [63:0]    rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic [18:0]    quo_ff, quo_in;
   logic [2:0][19:0] l_ff, l_in;
   logic signed [45:0] dot_ff, dot_in;
   logic signed [21:0] ndotl_ff, ndotl_in;
   logic [2:0][23:0] r_ff, r_in;
   logic signed [26:0] rv_ff, rv_in;
   logic [36:0]    pw_ff, pw_in;
   logic [63:0]    prod_ff, prod_in;
   logic [50:0]    hi_ff, hi_in;
   logic [31:0]    ai_ff, ai_in;
   logic [TERM_W-1:0] term_ff, term_in;
   logic [2:0][ACC_WIDTH-1:0] dacc_ff, dacc_in, sacc_ff, sacc_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [19:0] n_cur, v_cur, l_cur;
   logic signed [23:0] r_cur;
   logic [15:0]    kd_cur, ks_cur, int_cur;
   logic [59:0]    sq_prod;
   logic signed [39:0] nl_prod;
   logic signed [41:0] rf_prod;
   logic signed [43:0] rv_prod;
   logic [63:0]    sq_try;
   logic           div_ge;
   logic [18:0]    quo_next;
   logic signed [27:0] rnd_dot;
   logic [62:0]    pw_prod;
   logic [63:0]    pw_rnd;
   logic [32:0]    mx01;

   function automatic logic signed [27:0] rnd18(input logic signed [45:0] x);
      logic [45:0] mag;
      logic [45:0] sum;
      logic [27:0] m;
      mag = x[45] ? 46'(-x) : 46'(x);
      sum = mag + 46'(1 << 17);
      m   = sum[45:18];
      rnd18 = x[45] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] acc,
                                                    input logic [TERM_W-1:0] term);
      logic [SUM_W-1:0] s;
      s = SUM_W'(acc) + SUM_W'(term);
      sat_add = (|s[SUM_W-1:ACC_WIDTH]) ? '1 : s[ACC_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] sat32(input logic [ACC_WIDTH-1:0] acc);
      logic [63:0] w;
      w = 64'(acc);
      sat32 = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

   assign n_cur   = $signed(item_ff.normal[20*idx_ff +: 20]);
   assign v_cur   = $signed(item_ff.view[20*idx_ff +: 20]);
   assign l_cur   = $signed(l_ff[idx_ff]);
   assign r_cur   = $signed(r_ff[idx_ff]);
   assign kd_cur  = item_ff.kd[16*idx_ff +: 16];
   assign ks_cur  = item_ff.ks[16*idx_ff +: 16];
   assign int_cur = light_int[idx_ff];

   assign sq_prod  = 60'(mag_ff[idx_ff][29:0]) * 60'(mag_ff[idx_ff][29:0]);
   assign nl_prod  = n_cur * l_cur;
   assign rf_prod  = ndotl_ff * n_cur;
   assign rv_prod  = r_cur * v_cur;
   assign sq_try   = res_ff + bit_ff;
   assign div_ge   = rem_ff >= bit_ff;
   assign quo_next = {quo_ff[17:0], div_ge};
   assign rnd_dot  = rnd18(dot_ff);
   assign pw_prod  = 63'(pw_ff) * 63'(rv_ff[25:0]);
   assign pw_rnd   = (prod_ff + 64'd131072) >> 18;

   always_comb begin
      logic [32:0] a0, a1, a2;
      a0 = q_item.delta[0][32] ? 33'd0 - q_item.delta[0] : q_item.delta[0];
      a1 = q_item.delta[1][32] ? 33'd0 - q_item.delta[1] : q_item.delta[1];
      a2 = q_item.delta[2][32] ? 33'd0 - q_item.delta[2] : q_item.delta[2];
      mx01 = (a0 > a1) ? a0 : a1;
      mx01 = (mx01 > a2) ? mx01 : a2;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      pcnt_in      = pcnt_ff;
      mag_in       = mag_ff;
      max_in       = max_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      quo_in       = quo_ff;
      l_in         = l_ff;
      dot_in       = dot_ff;
      ndotl_in     = ndotl_ff;
      r_in         = r_ff;
      rv_in        = rv_ff;
      pw_in        = pw_ff;
      prod_in      = prod_ff;
      hi_in        = hi_ff;
      ai_in        = ai_ff;
      term_in      = term_ff;
      dacc_in      = dacc_ff;
      sacc_in      = sacc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      stat.pop     = 1'b0;
      stat.busy    = state_ff != BK_IDLE;

      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               stat.pop = 1'b1;
               item_in  = q_item;
               idx_in   = 2'd0;
               dot_in   = '0;
               if (q_item.clear_first) begin
                  dacc_in = '0;
                  sacc_in = '0;
               end
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = q_item.delta[i][32] ? 33'd0 - q_item.delta[i]
                                                  : q_item.delta[i];
               end
               max_in = mx01;
               if (q_item.shadowed) begin
                  state_in = BK_DONE;
               end else if (mx01 == '0) begin
                  // light on the hit point: direction is zero
                  l_in     = '0;
                  state_in = BK_NL;
               end else begin
                  state_in = BK_NORM;
               end
            end
         end
         BK_NORM: begin
            if (max_ff[32:30] != '0) begin
               max_in = max_ff >> 1;
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (!max_ff[29]) begin
               max_in = max_ff << 1;
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               sq_in    = '0;
               idx_in   = 2'd0;
               state_in = BK_SQ;
            end
         end
         BK_SQ: begin
            sq_in  = sq_ff + 62'(sq_prod);
            idx_in = idx_ff + 1'b1;
            if (idx_ff == 2'd2) begin
               rem_in   = 64'(sq_ff + 62'(sq_prod));
               res_in   = '0;
               bit_in   = 64'h4000_0000_0000_0000;
               state_in = BK_SQRT;
            end
         end
         BK_SQRT: begin
            if (bit_ff == '0) begin
               idx_in   = 2'd0;
               state_in = BK_DIVLD;
            end else begin
               if (rem_ff >= sq_try) begin
                  rem_in = rem_ff - sq_try;
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         BK_DIVLD: begin
            rem_in   = 64'({mag_ff[idx_ff][29:0], 18'd0}) + (res_ff >> 1);
            bit_in   = res_ff << 18;
            quo_in   = '0;
            cnt_in   = 5'd18;
            state_in = BK_DIV;
         end
         BK_DIV: begin
            if (div_ge) begin
               rem_in = rem_ff - bit_ff;
            end
            quo_in = quo_next;
            bit_in = bit_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               l_in[idx_ff] = item_ff.delta[idx_ff][32] ? 20'd0 - 20'(quo_next)
                                                        : 20'(quo_next);
               idx_in = idx_ff + 1'b1;
               if (idx_ff == 2'd2) begin
                  idx_in   = 2'd0;
                  dot_in   = '0;
                  state_in = BK_NL;
               end else begin
                  state_in = BK_DIVLD;
               end
            end
         end
         BK_NL: begin
            dot_in = dot_ff + 46'(nl_prod);
            idx_in = idx_ff + 1'b1;
            if (idx_ff == 2'd2) begin
               state_in = BK_NLR;
            end
         end
         BK_NLR: begin
            ndotl_in = 22'(rnd_dot);
            idx_in   = 2'd0;
            state_in = BK_RFM;
         end
         BK_RFM: begin
            dot_in   = 46'(rf_prod) <<< 1;
            state_in = BK_RFR;
         end
         BK_RFR: begin
            r_in[idx_ff] = 24'(rnd_dot - 28'(l_cur));
            idx_in       = idx_ff + 1'b1;
            if (idx_ff == 2'd2) begin
               idx_in   = 2'd0;
               dot_in   = '0;
               state_in = BK_RV;
            end else begin
               state_in = BK_RFM;
            end
         end
         BK_RV: begin
            dot_in = dot_ff + 46'(rv_prod);
            idx_in = idx_ff + 1'b1;
            if (idx_ff == 2'd2) begin
               state_in = BK_RVR;
            end
         end
         BK_RVR: begin
            rv_in    = 27'(rnd_dot);
            idx_in   = 2'd0;
            state_in = (ndotl_ff > 0) ? BK_DFA : BK_SPCHK;
         end
         BK_DFA: begin
            ai_in    = 32'(int_cur) * 32'(kd_cur);
            state_in = BK_DFM;
         end
         BK_DFM: begin
            prod_in  = 64'(53'(ai_ff) * 53'(ndotl_ff[20:0])) + 64'h1000_0000;
            state_in = BK_DFACC;
         end
         BK_DFACC: begin
            dacc_in[idx_ff] = sat_add(dacc_ff[idx_ff], TERM_W'(prod_ff[63:29]));
            idx_in          = idx_ff + 1'b1;
            if (idx_ff == 2'd2) begin
               idx_in   = 2'd0;
               state_in = BK_SPCHK;
            end else begin
               state_in = BK_DFA;
            end
         end
         BK_SPCHK: begin
            idx_in = 2'd0;
            if (rv_ff[26]) begin
               state_in = BK_DONE;
            end else begin
               pw_in    = 37'(1 << 18);
               pcnt_in  = item_ff.expo;
               state_in = BK_PWM;
            end
         end
         BK_PWM: begin
            if (pcnt_ff == '0) begin
               state_in = BK_SPA;
            end else begin
               prod_in  = 64'(pw_prod);
               state_in = BK_PWR;
            end
         end
         BK_PWR: begin
            // hold the power at its cap
            pw_in    = (pw_rnd > 64'h10_0000_0000) ? 37'h10_0000_0000 : 37'(pw_rnd);
            pcnt_in  = pcnt_ff - 1'b1;
            state_in = BK_PWM;
         end
         BK_SPA: begin
            ai_in    = 32'(int_cur) * 32'(ks_cur);
            state_in = BK_SPH;
         end
         BK_SPH: begin
            hi_in    = 51'(ai_ff) * 51'(pw_ff[36:18]);
            state_in = BK_SPL;
         end
         BK_SPL: begin
            prod_in  = 64'(51'(ai_ff) * 51'(pw_ff[17:0]) + 51'h1000_0000);
            state_in = BK_SPT;
         end
         BK_SPT: begin
            term_in  = TERM_W'((52'(hi_ff) + 52'(prod_ff[50:18])) >> 11);
            state_in = BK_SPACC;
         end
         BK_SPACC: begin
            sacc_in[idx_ff] = sat_add(sacc_ff[idx_ff], term_ff);
            idx_in          = idx_ff + 1'b1;
            if (idx_ff == 2'd2) begin
               state_in = BK_DONE;
            end else begin
               state_in = BK_SPA;
            end
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {sat32(sacc_ff[2]), sat32(sacc_ff[1]), sat32(sacc_ff[0]),
                               sat32(dacc_ff[2]), sat32(dacc_ff[1]), sat32(dacc_ff[0])};
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         dacc_ff      <= '0;
         sacc_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dacc_ff      <= dacc_in;
         sacc_ff      <= sacc_in;
      end
      item_ff     <= item_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      pcnt_ff     <= pcnt_in;
      mag_ff      <= mag_in;
      max_ff      <= max_in;
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      quo_ff      <= quo_in;
      l_ff        <= l_in;
      dot_ff      <= dot_in;
      ndotl_ff    <= ndotl_in;
      r_ff        <= r_in;
      rv_ff       <= rv_in;
      pw_ff       <= pw_in;
      prod_ff     <= prod_in;
      hi_ff       <= hi_in;
      ai_ff       <= ai_in;
      term_ff     <= term_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
